// File: rtl/core/bnms_pkg.sv
// Package for the box suppression block: sizes, queue entry type, reset threshold.
// No dependencies.
package bnms_pkg;
  localparam int MAX_BOXES = 64;
  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [15:0] THR_RESET = 16'd19661;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic        last;
  } box_t;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
endpackage

// File: rtl/core/bnms_front.sv
// Front part: input queue that decouples item acceptance from the engine.
// Depends on bnms_pkg.
module bnms_front import bnms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  box_t in_box,
  output logic q_valid,
  input  logic q_ready,
  output box_t q_box
);
  box_t mem_r [QDEPTH];
  logic [QAW:0] wp_r, rp_r;
  logic full, empty;

  assign full  = (wp_r[QAW] != rp_r[QAW]) && (wp_r[QAW-1:0] == rp_r[QAW-1:0]);
  assign empty = (wp_r == rp_r);
  assign in_ready = !full;
  assign q_valid  = !empty;
  assign q_box    = mem_r[rp_r[QAW-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (in_valid && !full) wp_r <= wp_r + 1'b1;
      if (q_ready && !empty) rp_r <= rp_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (in_valid && !full) mem_r[wp_r[QAW-1:0]] <= in_box;
  end
endmodule

// File: rtl/core/bnms_back.sv
// Back part: box store, exchange sort, IoU suppression and result emission.
// Depends on bnms_pkg.
module bnms_back import bnms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] thr,
  input  logic        q_valid,
  output logic        q_ready,
  input  box_t        q_box,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_kept_x,
  output logic [15:0] out_kept_y,
  output logic [15:0] out_kept_w,
  output logic [15:0] out_kept_h,
  output logic [15:0] out_kept_score,
  output logic        out_final_kept,
  output logic        out_overflow
);
  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001, S_SRD = 7'b0000010, S_SCMP = 7'b0000100,
    S_NRD  = 7'b0001000, S_NA  = 7'b0010000, S_NB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  // stores: small register arrays, indexed by counters
  logic [63:0] coord_r [MAX_BOXES];
  logic [15:0] score_r [MAX_BOXES];
  logic [31:0] area_r  [MAX_BOXES];
  logic [MAX_BOXES-1:0] keep_r;
  logic [CW-1:0] cnt_r;
  logic ovf_r;
  st_t st_r;
  logic [IW-1:0] i_r, j_r;

  // registered operands
  logic [63:0] ca_r, cb_r;
  logic [31:0] aa_r, ab_r;
  logic [15:0] sa_r, sb_r;
  // IoU pipeline stage registers
  logic [16:0] iw_r, ih_r;
  logic [32:0] sum_r;
  logic [32:0] inter_r;
  logic        pend_r;

  // output register
  logic ov_r;
  logic [79:0] ob_r;
  logic ofin_r, oovf_r;

  logic [IW-1:0] nm1;
  assign nm1 = IW'(cnt_r - 1'b1);
  assign q_ready = (st_r == S_LOAD);

  // keep bits of the current set only; bits past the count are masked off
  logic [MAX_BOXES-1:0] live;
  assign live = keep_r & ~({MAX_BOXES{1'b1}} << cnt_r);

  // intersection extents from registered operands
  logic [16:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;
  always_comb begin
    ax2 = {1'b0, ca_r[63:48]} + {1'b0, ca_r[31:16]};
    bx2 = {1'b0, cb_r[63:48]} + {1'b0, cb_r[31:16]};
    ay2 = {1'b0, ca_r[47:32]} + {1'b0, ca_r[15:0]};
    by2 = {1'b0, cb_r[47:32]} + {1'b0, cb_r[15:0]};
    x1  = (ca_r[63:48] > cb_r[63:48]) ? {1'b0, ca_r[63:48]} : {1'b0, cb_r[63:48]};
    y1  = (ca_r[47:32] > cb_r[47:32]) ? {1'b0, ca_r[47:32]} : {1'b0, cb_r[47:32]};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
  end

  logic [33:0] uni;
  logic [49:0] lhs;
  logic [49:0] rhs;
  logic supp;
  always_comb begin
    uni  = {1'b0, sum_r} - {1'b0, inter_r};
    lhs  = {1'b0, inter_r, 16'h0};
    rhs  = 50'(uni) * 50'(thr);
    supp = (inter_r < sum_r) && (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; keep_r <= '1;
      i_r <= '0; j_r <= '0; ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && !(st_r == S_OUT && keep_r[i_r])) ov_r <= 1'b0;
      case (st_r)
        S_LOAD: begin
          if (q_valid) begin
            if (cnt_r < CW'(MAX_BOXES)) begin
              coord_r[cnt_r[IW-1:0]] <= {q_box.x, q_box.y, q_box.w, q_box.h};
              score_r[cnt_r[IW-1:0]] <= q_box.score;
              area_r[cnt_r[IW-1:0]]  <= 32'(q_box.w) * 32'(q_box.h);
              cnt_r <= cnt_r + 1'b1;
            end else ovf_r <= 1'b1;
            if (q_box.last) begin
              i_r <= '0; j_r <= IW'(1);
              st_r <= S_SRD;
            end
          end
        end
        // sort: load pair i,j
        S_SRD: begin
          if (cnt_r < CW'(2) || i_r >= nm1) begin
            i_r <= '0; st_r <= S_NRD;
          end else begin
            ca_r <= coord_r[i_r]; cb_r <= coord_r[j_r];
            aa_r <= area_r[i_r];  ab_r <= area_r[j_r];
            sa_r <= score_r[i_r]; sb_r <= score_r[j_r];
            st_r <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (sa_r < sb_r) begin
            coord_r[i_r] <= cb_r; coord_r[j_r] <= ca_r;
            area_r[i_r]  <= ab_r; area_r[j_r]  <= aa_r;
            score_r[i_r] <= sb_r; score_r[j_r] <= sa_r;
          end
          if (j_r == nm1) begin
            i_r <= i_r + 1'b1; j_r <= i_r + IW'(2);
          end else j_r <= j_r + 1'b1;
          st_r <= S_SRD;
        end
        // suppression: pick next kept i
        S_NRD: begin
          if (CW'(i_r) + 1'b1 >= cnt_r) begin
            i_r <= '0; st_r <= S_OUT;
          end else if (!keep_r[i_r]) i_r <= i_r + 1'b1;
          else begin
            j_r <= i_r + 1'b1; st_r <= S_NA;
          end
        end
        S_NA: begin
          ca_r <= coord_r[i_r]; cb_r <= coord_r[j_r];
          aa_r <= area_r[i_r];  ab_r <= area_r[j_r];
          st_r <= S_NB; pend_r <= 1'b0;
        end
        S_NB: begin
          if (!pend_r) begin
            iw_r <= (x2 > x1) ? x2 - x1 : '0;
            ih_r <= (y2 > y1) ? y2 - y1 : '0;
            sum_r <= {1'b0, aa_r} + {1'b0, ab_r};
            pend_r <= 1'b1;
            inter_r <= '0;
          end else if (inter_r == '0 && iw_r != '0 && ih_r != '0 && pend_r) begin
            inter_r <= {16'h0, iw_r} * {16'h0, ih_r};
            iw_r <= '0;
          end else begin
            if (supp) keep_r[j_r] <= 1'b0;
            if (CW'(j_r) == cnt_r - 1'b1) begin
              i_r <= i_r + 1'b1; st_r <= S_NRD;
            end else begin
              j_r <= j_r + 1'b1; st_r <= S_NA;
            end
          end
        end
        // emission through the output register
        S_OUT: begin
          if (!ov_r || out_ready) begin
            if (keep_r[i_r]) begin
              ov_r <= 1'b1;
              ob_r <= {coord_r[i_r], score_r[i_r]};
              oovf_r <= ovf_r;
              ofin_r <= ~|(live >> (CW'(i_r) + 1'b1));
            end
            if (CW'(i_r) + 1'b1 == cnt_r) begin
              st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; keep_r <= '1;
            end else i_r <= i_r + 1'b1;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  // result outputs
  assign out_valid      = ov_r;
  assign out_kept_x     = ob_r[79:64];
  assign out_kept_y     = ob_r[63:48];
  assign out_kept_w     = ob_r[47:32];
  assign out_kept_h     = ob_r[31:16];
  assign out_kept_score = ob_r[15:0];
  assign out_final_kept = ofin_r;
  assign out_overflow   = oovf_r;
endmodule

// File: rtl/core/box_non_max_suppression_top.sv
// Greedy NMS top: loads up to 64 boxes, sorts them by exchange sort,
// suppresses by IoU, then walks the set one entry a cycle while out_ready does not stall it.
// Sort and suppression handle one pair at a time; no box leaves the queue until the whole set
// is emitted, and the first result follows the last box by the whole sort and suppression.
// Reset (rst_n low, synchronous) empties the queue, clears the set, restores threshold 0.3.
// Depends on bnms_pkg, bnms_front, bnms_back.
module box_non_max_suppression_top import bnms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_overlap_threshold,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_box_x,
  input  logic [15:0] in_box_y,
  input  logic [15:0] in_box_w,
  input  logic [15:0] in_box_h,
  input  logic [15:0] in_box_score,
  input  logic        in_last_box,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_kept_x,
  output logic [15:0] out_kept_y,
  output logic [15:0] out_kept_w,
  output logic [15:0] out_kept_h,
  output logic [15:0] out_kept_score,
  output logic        out_final_kept,
  output logic        out_overflow
);
  logic [15:0] thr_r;
  box_t in_box, q_box;
  logic q_valid, q_ready;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (cfg_we) thr_r <= cfg_overlap_threshold;
  end

  assign in_box = '{x: in_box_x, y: in_box_y, w: in_box_w, h: in_box_h,
                    score: in_box_score, last: in_last_box};

  bnms_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_box,
    .q_valid, .q_ready, .q_box
  );

  bnms_back u_back (
    .clk, .rst_n, .thr(thr_r), .q_valid, .q_ready, .q_box,
    .out_valid, .out_ready, .out_kept_x, .out_kept_y, .out_kept_w,
    .out_kept_h, .out_kept_score, .out_final_kept, .out_overflow
  );
endmodule
